[rtl/core/heading_pid_rate_limited_unit_defines.svh]
// Assertion macros for the heading PID unit.
// Defining ASSERT_OFF compiles every check out; no other dependencies.
`ifndef HEADING_PID_RATE_LIMITED_UNIT_DEFINES_SVH
`define HEADING_PID_RATE_LIMITED_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define HPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define HPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/hpid_pkg.sv]
// Shared types, constants and helpers for the heading PID unit.
// No dependencies; hpid_cfg, hpid_alu, hpid_seq and the top level refer to it by scope.
package hpid_pkg;

  // fixed-point format of angles, integral and steering
  localparam int     FRAC_BITS = 12;
  localparam longint PI_Q29    = 64'sd1686629713;
  localparam longint PI_Q      = (PI_Q29 + (longint'(1) << (28 - FRAC_BITS)))
                                 >>> (29 - FRAC_BITS);
  localparam longint TWO_PI    = 2 * PI_Q;

  // field and datapath widths
  localparam int ERR_W   = 15;
  localparam int DT_IN_W = 16;
  localparam int DT_W    = 14;
  localparam int STEER_W = 16;
  localparam int BOUND_W = 15;
  localparam int GAIN_W  = 16;
  localparam int ALPHA_W = 13;
  localparam int INTEG_W = 16;
  localparam int DF_W    = 32;
  localparam int RAW_W   = 33;
  localparam int MA_W    = 17;
  localparam int MB_W    = 33;
  localparam int PROD_W  = 50;
  localparam int ACC_W   = 51;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // divider: |wrapped diff| << 16 over dt, one quotient bit per cycle
  localparam int DT_SHIFT = 16;
  localparam int DMAG_W   = $clog2(PI_Q + 1);
  localparam int QW       = DMAG_W + DT_SHIFT;
  localparam int CNT_W    = $clog2(QW);
  localparam int REM_W    = DT_W + 1;

  localparam int ALPHA_SH = 12;
  localparam int GAIN_SH  = 8;

  localparam logic [DT_IN_W-1:0] DT_MIN    = 16'd66;
  localparam logic [DT_IN_W-1:0] DT_MAX    = 16'd13107;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 13'd4096;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_DERIV_ALPHA,
    REG_INTEGRAL_BOUND,
    REG_STEER_BOUND,
    REG_STEER_SLEW
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [ALPHA_W-1:0] deriv_alpha;
    logic [BOUND_W-1:0] integral_bound;
    logic [BOUND_W-1:0] steer_bound;
    logic [BOUND_W-1:0] steer_slew;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_WRAP,
    ST_DIV,
    ST_NEG,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_I1,
    ST_I2,
    ST_LIM,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_STEP,
    ST_DONE
  } state_t;

  // adder operand pairs
  typedef enum logic [3:0] {
    A_NONE,
    A_DIFF,
    A_WRAP_DN,
    A_WRAP_UP,
    A_ABS,
    A_DIV,
    A_NEG,
    A_SET12,
    A_ACC,
    A_RND16,
    A_INTEG,
    A_SET8,
    A_TGT,
    A_STEP
  } add_sel_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    M_NONE,
    M_ALPHA_RAW,
    M_BETA_DF,
    M_ERR_DT,
    M_SLEW_DT,
    M_GP_ERR,
    M_GI_INT,
    M_GD_DF
  } mul_sel_t;

  typedef struct packed {
    logic     ready;
    add_sel_t add_sel;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     ld_raw;
    logic     ld_df;
    logic     ld_integ;
    logic     ld_lim;
    logic     ld_fin;
  } ctrl_t;

  typedef struct packed {
    logic wrap_hi;
    logic wrap_lo;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic                    sub;
    logic                    mul_en;
    logic signed [MA_W-1:0]  ma;
    logic signed [MB_W-1:0]  mb;
  } alu_req_t;

  function automatic logic signed [ACC_W-1:0] clamp_sym(
    input logic signed [ACC_W-1:0] v,
    input logic [BOUND_W-1:0]      b
  );
    logic signed [ACC_W-1:0] bs;
    bs = ACC_W'(b);
    if (v > bs) begin
      return bs;
    end else if (v < -bs) begin
      return -bs;
    end
    return v;
  endfunction

endpackage

[rtl/core/hpid_cfg.sv]
// APB-style register file for the heading PID unit.
// Depends on hpid_pkg for the register map and the cfg_t bundle.
module hpid_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hpid_pkg::PADDR_W-1:0] paddr,
  input  logic [hpid_pkg::PDATA_W-1:0] pwdata,
  output logic [hpid_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output hpid_pkg::cfg_t               cfg
);

  hpid_pkg::cfg_t   cfg_r;
  hpid_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = hpid_pkg::reg_idx_t'(paddr[hpid_pkg::PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= 16'd256;
      cfg_r.gain_i         <= 16'd0;
      cfg_r.gain_d         <= 16'd0;
      cfg_r.deriv_alpha    <= hpid_pkg::ALPHA_ONE;
      cfg_r.integral_bound <= 15'd4096;
      cfg_r.steer_bound    <= 15'd4096;
      cfg_r.steer_slew     <= 15'd8192;
    end else if (wr_en) begin
      case (idx)
        hpid_pkg::REG_GAIN_P:         cfg_r.gain_p         <= pwdata[15:0];
        hpid_pkg::REG_GAIN_I:         cfg_r.gain_i         <= pwdata[15:0];
        hpid_pkg::REG_GAIN_D:         cfg_r.gain_d         <= pwdata[15:0];
        hpid_pkg::REG_DERIV_ALPHA:    cfg_r.deriv_alpha    <= pwdata[12:0];
        hpid_pkg::REG_INTEGRAL_BOUND: cfg_r.integral_bound <= pwdata[14:0];
        hpid_pkg::REG_STEER_BOUND:    cfg_r.steer_bound    <= pwdata[14:0];
        hpid_pkg::REG_STEER_SLEW:     cfg_r.steer_slew     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hpid_pkg::REG_GAIN_P:         prdata = 32'(cfg_r.gain_p);
      hpid_pkg::REG_GAIN_I:         prdata = 32'(cfg_r.gain_i);
      hpid_pkg::REG_GAIN_D:         prdata = 32'(cfg_r.gain_d);
      hpid_pkg::REG_DERIV_ALPHA:    prdata = 32'(cfg_r.deriv_alpha);
      hpid_pkg::REG_INTEGRAL_BOUND: prdata = 32'(cfg_r.integral_bound);
      hpid_pkg::REG_STEER_BOUND:    prdata = 32'(cfg_r.steer_bound);
      hpid_pkg::REG_STEER_SLEW:     prdata = 32'(cfg_r.steer_slew);
      default:                      prdata = '0;
    endcase
  end

endmodule

[rtl/core/hpid_alu.sv]
// Shared arithmetic unit: one wide adder/subtractor and one registered
// 17x33 signed multiplier. Depends on hpid_pkg for alu_req_t.
module hpid_alu (
  input  logic                                clk,
  input  hpid_pkg::alu_req_t                  req,
  output logic signed [hpid_pkg::ACC_W-1:0]   sum,
  output logic signed [hpid_pkg::PROD_W-1:0]  prod
);

  logic signed [hpid_pkg::PROD_W-1:0] prod_r;

  assign sum  = req.sub ? (req.x - req.y) : (req.x + req.y);
  assign prod = prod_r;

  // product holds until the next multiply is issued
  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod_r <= hpid_pkg::PROD_W'(req.ma) * hpid_pkg::PROD_W'(req.mb);
    end
  end

endmodule

[rtl/core/hpid_seq.sv]
// Step sequencer of the heading PID unit: walks the shared unit through
// one control update. Depends on hpid_pkg for state_t, ctrl_t and stat_t.
module hpid_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  hpid_pkg::stat_t stat,
  output hpid_pkg::ctrl_t ctrl
);

  hpid_pkg::state_t           state_r, state_nxt;
  logic [hpid_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpid_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      hpid_pkg::ST_IDLE: if (in_valid) state_nxt = hpid_pkg::ST_DIFF;
      hpid_pkg::ST_DIFF: state_nxt = hpid_pkg::ST_WRAP;
      hpid_pkg::ST_WRAP: begin
        cnt_nxt = '0;
        if (!stat.wrap_hi && !stat.wrap_lo) state_nxt = hpid_pkg::ST_DIV;
      end
      hpid_pkg::ST_DIV: begin
        cnt_nxt = hpid_pkg::CNT_W'(cnt_r + 1'b1);
        if (cnt_r == hpid_pkg::CNT_W'(hpid_pkg::QW - 1)) state_nxt = hpid_pkg::ST_NEG;
      end
      hpid_pkg::ST_NEG:  state_nxt = hpid_pkg::ST_F1;
      hpid_pkg::ST_F1:   state_nxt = hpid_pkg::ST_F2;
      hpid_pkg::ST_F2:   state_nxt = hpid_pkg::ST_F3;
      hpid_pkg::ST_F3:   state_nxt = hpid_pkg::ST_F4;
      hpid_pkg::ST_F4:   state_nxt = hpid_pkg::ST_I1;
      hpid_pkg::ST_I1:   state_nxt = hpid_pkg::ST_I2;
      hpid_pkg::ST_I2:   state_nxt = hpid_pkg::ST_LIM;
      hpid_pkg::ST_LIM:  state_nxt = hpid_pkg::ST_T1;
      hpid_pkg::ST_T1:   state_nxt = hpid_pkg::ST_T2;
      hpid_pkg::ST_T2:   state_nxt = hpid_pkg::ST_T3;
      hpid_pkg::ST_T3:   state_nxt = hpid_pkg::ST_T4;
      hpid_pkg::ST_T4:   state_nxt = hpid_pkg::ST_STEP;
      hpid_pkg::ST_STEP: state_nxt = hpid_pkg::ST_DONE;
      hpid_pkg::ST_DONE: if (stat.out_free) state_nxt = hpid_pkg::ST_IDLE;
      default:           state_nxt = hpid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.add_sel = hpid_pkg::A_NONE;
    ctrl.mul_sel = hpid_pkg::M_NONE;
    case (state_r)
      hpid_pkg::ST_IDLE: ctrl.ready = 1'b1;
      hpid_pkg::ST_DIFF: ctrl.add_sel = hpid_pkg::A_DIFF;
      hpid_pkg::ST_WRAP: begin
        if (stat.wrap_hi) begin
          ctrl.add_sel = hpid_pkg::A_WRAP_DN;
        end else if (stat.wrap_lo) begin
          ctrl.add_sel = hpid_pkg::A_WRAP_UP;
        end else begin
          ctrl.add_sel  = hpid_pkg::A_ABS;
          ctrl.div_init = 1'b1;
        end
      end
      hpid_pkg::ST_DIV: begin
        ctrl.add_sel  = hpid_pkg::A_DIV;
        ctrl.div_step = 1'b1;
      end
      hpid_pkg::ST_NEG: begin
        ctrl.add_sel = hpid_pkg::A_NEG;
        ctrl.ld_raw  = 1'b1;
      end
      hpid_pkg::ST_F1: begin
        ctrl.add_sel = hpid_pkg::A_SET12;
        ctrl.mul_sel = hpid_pkg::M_ALPHA_RAW;
      end
      hpid_pkg::ST_F2: begin
        ctrl.add_sel = hpid_pkg::A_ACC;
        ctrl.mul_sel = hpid_pkg::M_BETA_DF;
      end
      hpid_pkg::ST_F3: begin
        ctrl.add_sel = hpid_pkg::A_ACC;
        ctrl.mul_sel = hpid_pkg::M_ERR_DT;
      end
      hpid_pkg::ST_F4: begin
        ctrl.add_sel = hpid_pkg::A_RND16;
        ctrl.mul_sel = hpid_pkg::M_SLEW_DT;
        ctrl.ld_df   = 1'b1;
      end
      hpid_pkg::ST_I1: ctrl.add_sel = hpid_pkg::A_INTEG;
      hpid_pkg::ST_I2: begin
        ctrl.add_sel  = hpid_pkg::A_RND16;
        ctrl.ld_integ = 1'b1;
      end
      hpid_pkg::ST_LIM: begin
        ctrl.add_sel = hpid_pkg::A_SET8;
        ctrl.mul_sel = hpid_pkg::M_GP_ERR;
        ctrl.ld_lim  = 1'b1;
      end
      hpid_pkg::ST_T1: begin
        ctrl.add_sel = hpid_pkg::A_ACC;
        ctrl.mul_sel = hpid_pkg::M_GI_INT;
      end
      hpid_pkg::ST_T2: begin
        ctrl.add_sel = hpid_pkg::A_ACC;
        ctrl.mul_sel = hpid_pkg::M_GD_DF;
      end
      hpid_pkg::ST_T3:   ctrl.add_sel = hpid_pkg::A_ACC;
      hpid_pkg::ST_T4:   ctrl.add_sel = hpid_pkg::A_TGT;
      hpid_pkg::ST_STEP: ctrl.add_sel = hpid_pkg::A_STEP;
      hpid_pkg::ST_DONE: ctrl.ld_fin = stat.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/core/heading_pid_rate_limited_unit.sv]
// Top level of the heading PID unit: datapath registers and operand muxes.
// Depends on hpid_pkg, hpid_cfg, hpid_alu, hpid_seq and the defines header.
//
//   channel   dir  handshake             payload
//   in        in   in_valid / in_ready   in_heading_err, in_step_time, in_restart
//   out       out  out_valid / out_ready out_steer_out
//   config    in   psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// A new item is taken only in the idle state, once the previous one has passed the
// difference, wrap (repeated for each correction), divide, sign, filter, integral,
// limit, target, step and done states; the bit-serial divide through the shared adder is the longest part.
// Reset loads the register defaults and clears the controller state.
// A result waiting on out_ready does not block the next input transfer; the
// following result is held in its last step until the output register frees.
`include "heading_pid_rate_limited_unit_defines.svh"

module heading_pid_rate_limited_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hpid_pkg::PADDR_W-1:0]        paddr,
  input  logic [hpid_pkg::PDATA_W-1:0]        pwdata,
  output logic [hpid_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hpid_pkg::ERR_W-1:0]   in_heading_err,
  input  logic [hpid_pkg::DT_IN_W-1:0]        in_step_time,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hpid_pkg::STEER_W-1:0] out_steer_out
);

  localparam int ACC_W = hpid_pkg::ACC_W;
  localparam int QW    = hpid_pkg::QW;
  localparam logic signed [ACC_W-1:0] PI_A   = ACC_W'(hpid_pkg::PI_Q);
  localparam logic signed [ACC_W-1:0] TWO_A  = ACC_W'(hpid_pkg::TWO_PI);
  localparam logic signed [ACC_W-1:0] DF_MAX =
    ACC_W'((longint'(1) << (hpid_pkg::DF_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] DF_MIN = -DF_MAX - 1;
  localparam logic signed [ACC_W-1:0] HALF_A =
    ACC_W'(longint'(1) << (hpid_pkg::ALPHA_SH - 1));
  localparam logic signed [ACC_W-1:0] HALF_T =
    ACC_W'(longint'(1) << (hpid_pkg::DT_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] HALF_G =
    ACC_W'(longint'(1) << (hpid_pkg::GAIN_SH - 1));

  hpid_pkg::cfg_t     cfg;
  hpid_pkg::ctrl_t    ctrl;
  hpid_pkg::stat_t    stat;
  hpid_pkg::alu_req_t req;

  logic signed [ACC_W-1:0]            sum;
  logic signed [hpid_pkg::PROD_W-1:0] prod;

  // item and controller state
  logic signed [hpid_pkg::ERR_W-1:0]   err_r;
  logic [hpid_pkg::DT_W-1:0]           dt_r;
  logic signed [hpid_pkg::ERR_W-1:0]   last_r;
  logic signed [hpid_pkg::DF_W-1:0]    df_r;
  logic signed [hpid_pkg::INTEG_W-1:0] integ_r;
  logic signed [hpid_pkg::STEER_W-1:0] held_r;
  logic signed [ACC_W-1:0]             acc_r;
  logic signed [hpid_pkg::RAW_W-1:0]   raw_r;
  logic [hpid_pkg::BOUND_W-1:0]        lim_r;
  logic [hpid_pkg::DT_W-1:0]           rem_r;
  logic [QW-1:0]                       dvq_r;
  logic                                neg_r;
  logic                                out_valid_r;
  logic signed [hpid_pkg::STEER_W-1:0] out_steer_r;

  logic                          in_fire;
  logic                          acc_ld;
  logic [hpid_pkg::REM_W-1:0]    rem2;
  logic                          qbit;
  logic [hpid_pkg::ALPHA_W-1:0]  a_eff;
  logic [hpid_pkg::ALPHA_W-1:0]  beta;
  logic [hpid_pkg::DT_W-1:0]     dt_c;
  logic signed [ACC_W-1:0]       sh12, sh16, sh8;
  logic signed [ACC_W-1:0]       df_c;
  logic signed [ACC_W-1:0]       step_d;

  hpid_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hpid_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  hpid_alu u_alu (
    .clk  (clk),
    .req  (req),
    .sum  (sum),
    .prod (prod)
  );

  assign in_ready      = ctrl.ready;
  assign in_fire       = in_valid && ctrl.ready;
  assign out_valid     = out_valid_r;
  assign out_steer_out = out_steer_r;

  assign stat.wrap_hi  = acc_r > PI_A;
  assign stat.wrap_lo  = acc_r <= -PI_A;
  assign stat.out_free = !out_valid_r || out_ready;

  assign a_eff = (cfg.deriv_alpha > hpid_pkg::ALPHA_ONE) ? hpid_pkg::ALPHA_ONE
                                                         : cfg.deriv_alpha;
  assign beta  = hpid_pkg::ALPHA_ONE - a_eff;

  assign sh12 = acc_r >>> hpid_pkg::ALPHA_SH;
  assign sh16 = acc_r >>> hpid_pkg::DT_SHIFT;
  assign sh8  = acc_r >>> hpid_pkg::GAIN_SH;

  assign df_c   = (sh12 > DF_MAX) ? DF_MAX : ((sh12 < DF_MIN) ? DF_MIN : sh12);
  assign step_d = acc_r - ACC_W'(held_r);

  // divider: shift one dividend bit into the partial remainder per step
  assign rem2 = {rem_r, dvq_r[QW-1]};
  assign qbit = !sum[ACC_W-1];

  always_comb begin
    if (in_step_time < hpid_pkg::DT_MIN) begin
      dt_c = hpid_pkg::DT_MIN[hpid_pkg::DT_W-1:0];
    end else if (in_step_time > hpid_pkg::DT_MAX) begin
      dt_c = hpid_pkg::DT_MAX[hpid_pkg::DT_W-1:0];
    end else begin
      dt_c = in_step_time[hpid_pkg::DT_W-1:0];
    end
  end

  always_comb begin
    acc_ld = !(ctrl.add_sel inside {hpid_pkg::A_NONE, hpid_pkg::A_DIV, hpid_pkg::A_NEG});
  end

  always_comb begin
    req.x      = '0;
    req.y      = '0;
    req.sub    = 1'b0;
    req.mul_en = (ctrl.mul_sel != hpid_pkg::M_NONE);
    req.ma     = '0;
    req.mb     = '0;
    // adder operands
    case (ctrl.add_sel)
      hpid_pkg::A_DIFF: begin
        req.x   = ACC_W'(err_r);
        req.y   = ACC_W'(last_r);
        req.sub = 1'b1;
      end
      hpid_pkg::A_WRAP_DN: begin
        req.x   = acc_r;
        req.y   = TWO_A;
        req.sub = 1'b1;
      end
      hpid_pkg::A_WRAP_UP: begin
        req.x = acc_r;
        req.y = TWO_A;
      end
      hpid_pkg::A_ABS: begin
        req.y   = acc_r;
        req.sub = acc_r[ACC_W-1];
      end
      hpid_pkg::A_DIV: begin
        req.x   = ACC_W'(rem2);
        req.y   = ACC_W'(dt_r);
        req.sub = 1'b1;
      end
      hpid_pkg::A_NEG: begin
        req.y   = ACC_W'(dvq_r);
        req.sub = neg_r;
      end
      hpid_pkg::A_SET12: req.y = HALF_A;
      hpid_pkg::A_ACC: begin
        req.x = acc_r;
        req.y = ACC_W'(prod);
      end
      hpid_pkg::A_RND16: begin
        req.x = ACC_W'(prod);
        req.y = HALF_T;
      end
      hpid_pkg::A_INTEG: begin
        req.x = ACC_W'(integ_r);
        req.y = sh16;
      end
      hpid_pkg::A_SET8: req.y = HALF_G;
      hpid_pkg::A_TGT: begin
        req.x   = hpid_pkg::clamp_sym(sh8, cfg.steer_bound);
        req.y   = ACC_W'(held_r);
        req.sub = 1'b1;
      end
      hpid_pkg::A_STEP: begin
        req.x = ACC_W'(held_r);
        req.y = hpid_pkg::clamp_sym(acc_r, lim_r);
      end
      default: ;
    endcase
    // multiplier operands
    case (ctrl.mul_sel)
      hpid_pkg::M_ALPHA_RAW: begin
        req.ma = hpid_pkg::MA_W'(a_eff);
        req.mb = raw_r;
      end
      hpid_pkg::M_BETA_DF: begin
        req.ma = hpid_pkg::MA_W'(beta);
        req.mb = hpid_pkg::MB_W'(df_r);
      end
      hpid_pkg::M_ERR_DT: begin
        req.ma = hpid_pkg::MA_W'(err_r);
        req.mb = hpid_pkg::MB_W'(dt_r);
      end
      hpid_pkg::M_SLEW_DT: begin
        req.ma = hpid_pkg::MA_W'(cfg.steer_slew);
        req.mb = hpid_pkg::MB_W'(dt_r);
      end
      hpid_pkg::M_GP_ERR: begin
        req.ma = hpid_pkg::MA_W'(cfg.gain_p);
        req.mb = hpid_pkg::MB_W'(err_r);
      end
      hpid_pkg::M_GI_INT: begin
        req.ma = hpid_pkg::MA_W'(cfg.gain_i);
        req.mb = hpid_pkg::MB_W'(integ_r);
      end
      hpid_pkg::M_GD_DF: begin
        req.ma = hpid_pkg::MA_W'(cfg.gain_d);
        req.mb = hpid_pkg::MB_W'(df_r);
      end
      default: ;
    endcase
  end

  // controller state: cleared by reset; a restart item clears all of it but out_valid_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_r      <= '0;
      df_r        <= '0;
      integ_r     <= '0;
      held_r      <= '0;
    end else begin
      if (in_fire && in_restart) begin
        last_r  <= '0;
        df_r    <= '0;
        integ_r <= '0;
        held_r  <= '0;
      end
      if (ctrl.ld_df) begin
        df_r <= df_c[hpid_pkg::DF_W-1:0];
      end
      if (ctrl.ld_integ) begin
        integ_r <= hpid_pkg::INTEG_W'(hpid_pkg::clamp_sym(acc_r, cfg.integral_bound));
      end
      if (ctrl.ld_fin) begin
        held_r      <= acc_r[hpid_pkg::STEER_W-1:0];
        last_r      <= err_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r <= in_heading_err;
      dt_r  <= dt_c;
    end
    if (acc_ld) begin
      acc_r <= sum;
    end
    if (ctrl.div_init) begin
      rem_r <= '0;
      dvq_r <= {sum[hpid_pkg::DMAG_W-1:0], {hpid_pkg::DT_SHIFT{1'b0}}};
      neg_r <= acc_r[ACC_W-1];
    end
    if (ctrl.div_step) begin
      rem_r <= qbit ? sum[hpid_pkg::DT_W-1:0] : rem2[hpid_pkg::DT_W-1:0];
      dvq_r <= {dvq_r[QW-2:0], qbit};
    end
    if (ctrl.ld_raw) begin
      raw_r <= sum[hpid_pkg::RAW_W-1:0];
    end
    if (ctrl.ld_lim) begin
      lim_r <= sh16[hpid_pkg::BOUND_W-1:0];
    end
    if (ctrl.ld_fin) begin
      out_steer_r <= hpid_pkg::STEER_W'(hpid_pkg::clamp_sym(acc_r, cfg.steer_bound));
    end
  end

  `HPID_ASSERT_IMP(a_wrap_range, clk, rst_n, ctrl.div_init,
    (acc_r <= PI_A) && (acc_r > -PI_A), "wrapped difference out of range")
  `HPID_ASSERT_IMP(a_div_rem, clk, rst_n, ctrl.ld_raw, rem_r < dt_r,
    "divider remainder not below divisor")
  `HPID_ASSERT_IMP(a_slew, clk, rst_n, ctrl.ld_fin,
    (step_d <= $signed(ACC_W'(lim_r))) && (step_d >= -$signed(ACC_W'(lim_r))),
    "steering step exceeds slew limit")
  `HPID_ASSERT_NXT(a_out_bound, clk, rst_n, ctrl.ld_fin,
    out_valid_r && (ACC_W'(out_steer_r) <= $signed(ACC_W'(cfg.steer_bound)))
    && (ACC_W'(out_steer_r) >= -$signed(ACC_W'(cfg.steer_bound))),
    "steering output outside bound")

endmodule
